// ===== rtl/huff_pkg.sv =====
package huff_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int PEND_W  = 7;
  localparam int ACC_W   = PEND_W + CODE_W;
  localparam int CNT_W   = 6;
  localparam int VBITS_W = 4;
  localparam int TOTAL_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic              opcode;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  packed_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last;
    logic [TOTAL_W-1:0] total_bits;
    logic               error;
  } out_word_t;

  // classified item handed from the front to the packer
  typedef struct packed {
    logic              is_load;
    logic              err;
    logic              eos;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

// ===== rtl/huffman_code_bit_packer.sv =====
// Table-driven Huffman encoder with an MSB-first byte packer. A load word writes one
// symbol's code and length into the code table and returns one status word (error set
// when the length exceeds MAX_CODE_LEN). An encode word looks up its symbol and emits
// one output word per completed byte, plus one for a partial byte on end_of_stream;
// an encode that completes nothing returns no word. The front stage takes one input
// word per cycle unless stalled by a full queue, and reads the table through a
// registered read into a four-entry queue; the packer emits one output word per
// cycle unless the output stalls, and pops the next entry as it emits the last word
// of the current one.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  huff_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output huff_pkg::out_word_t out_word_o
);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  huff_pkg::entry_t push_word;
  huff_pkg::entry_t head;

  huff_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .push_o     (push),
    .push_word_o(push_word),
    .full_i     (full)
  );

  huff_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_word_i(push_word),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  huff_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (empty),
    .q_head_i   (head),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== rtl/huff_front.sv =====
module huff_front #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  huff_pkg::in_word_t in_word_i,
  output logic               push_o,
  output huff_pkg::entry_t   push_word_o,
  input  logic               full_i
);

  localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CW = MAX_CODE_LEN;
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int EW = CW + LW;

  logic [EW-1:0] mem_q [SYMBOL_COUNT];
  logic [EW-1:0] rd_q;

  logic s1_valid_q, s1_valid_d;
  logic s1_op_q, s1_eos_q, s1_err_q, s1_ok_q;

  logic          accept;
  logic          sym_ok;
  logic          len_bad;
  logic          wr_en;
  logic [AW-1:0] addr;
  logic [CW-1:0] code_mask;

  assign in_stall_o = s1_valid_q && full_i;
  assign push_o     = s1_valid_q && !full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign addr       = in_word_i.symbol[AW-1:0];
  assign sym_ok     = {1'b0, in_word_i.symbol} < 9'(SYMBOL_COUNT);
  assign len_bad    = in_word_i.code_length > huff_pkg::LEN_W'(MAX_CODE_LEN);
  assign wr_en      = accept && (in_word_i.opcode == huff_pkg::OP_LOAD) && !len_bad && sym_ok;

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      code_mask[i] = huff_pkg::LEN_W'(i) < in_word_i.code_length;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= {LW'(in_word_i.code_length), in_word_i.code_bits[CW-1:0] & code_mask};
    end
    if (accept) begin
      rd_q <= mem_q[addr];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= in_word_i.opcode;
      s1_eos_q <= in_word_i.end_of_stream;
      s1_err_q <= len_bad;
      s1_ok_q  <= sym_ok;
    end
  end

  always_comb begin
    push_word_o.is_load = s1_op_q == huff_pkg::OP_LOAD;
    push_word_o.err     = s1_err_q;
    push_word_o.eos     = s1_eos_q;
    push_word_o.code    = s1_ok_q ? huff_pkg::CODE_W'(rd_q[CW-1:0]) : '0;
    push_word_o.len     = s1_ok_q ? huff_pkg::LEN_W'(rd_q[EW-1:CW]) : '0;
  end

endmodule

// ===== rtl/huff_queue.sv =====
module huff_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  huff_pkg::entry_t push_word_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output huff_pkg::entry_t head_o
);

  huff_pkg::entry_t slot_q [huff_pkg::QUEUE_DEPTH];

  logic [huff_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [huff_pkg::QPTR_W:0]   fill_q;

  assign full_o  = fill_q == (huff_pkg::QPTR_W + 1)'(huff_pkg::QUEUE_DEPTH);
  assign empty_o = fill_q == '0;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + huff_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + huff_pkg::QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + (huff_pkg::QPTR_W + 1)'(1);
        2'b01:   fill_q <= fill_q - (huff_pkg::QPTR_W + 1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== rtl/huff_back.sv =====
module huff_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  huff_pkg::entry_t    q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output huff_pkg::out_word_t out_word_o
);

  logic                          busy_q, busy_d;
  logic                          ld_q, ld_d;
  logic                          err_q, err_d;
  logic                          eos_q, eos_d;
  logic [huff_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [huff_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [huff_pkg::TOTAL_W-1:0]  total_q, total_d;
  logic                          out_valid_q, out_valid_d;
  huff_pkg::out_word_t           out_q, out_d;

  always_comb begin
    logic                          out_free;
    logic                          emit;
    logic                          done;
    logic                          pop;
    logic [huff_pkg::CNT_W-1:0]    cnt_e;
    logic [huff_pkg::CNT_W-1:0]    cnt_n;
    logic [huff_pkg::TOTAL_W-1:0]  base_total;
    logic [huff_pkg::TOTAL_W:0]    sum;
    logic [huff_pkg::TOTAL_W-1:0]  tot_n;
    logic [huff_pkg::PEND_W-1:0]   pend;
    logic [huff_pkg::ACC_W-1:0]    acc_n;
    logic                          has_out;
    huff_pkg::out_word_t           res;

    out_free = !out_valid_q || !out_stall_i;
    emit     = 1'b0;
    done     = 1'b0;
    cnt_e    = cnt_q;
    res      = '0;

    if (busy_q && out_free) begin
      emit = 1'b1;
      if (ld_q) begin
        done           = 1'b1;
        res.last       = 1'b1;
        res.total_bits = total_q;
        res.error      = err_q;
      end else if (cnt_q >= huff_pkg::CNT_W'(8)) begin
        cnt_e           = cnt_q - huff_pkg::CNT_W'(8);
        done            = (cnt_e < huff_pkg::CNT_W'(8)) && !(eos_q && (cnt_e != '0));
        res.packed_byte = 8'(acc_q >> cnt_e);
        res.valid_bits  = huff_pkg::VBITS_W'(8);
        res.last        = done;
        res.total_bits  = total_q;
      end else begin
        // flush of the partial byte at end of stream
        cnt_e           = '0;
        done            = 1'b1;
        res.packed_byte = 8'(acc_q[7:0] << (4'd8 - cnt_q[3:0]));
        res.valid_bits  = huff_pkg::VBITS_W'(cnt_q);
        res.last        = 1'b1;
        res.total_bits  = total_q;
      end
    end

    base_total = (emit && done && eos_q) ? '0 : total_q;
    pop        = (!busy_q || (emit && done)) && !q_empty_i;
    q_pop_o    = pop;

    pend  = acc_q[huff_pkg::PEND_W-1:0] &
            huff_pkg::PEND_W'((8'd1 << cnt_e[2:0]) - 8'd1);
    acc_n = (huff_pkg::ACC_W'(pend) << q_head_i.len) | huff_pkg::ACC_W'(q_head_i.code);
    cnt_n = cnt_e + huff_pkg::CNT_W'(q_head_i.len);
    sum   = {1'b0, base_total} + (huff_pkg::TOTAL_W + 1)'(q_head_i.len);
    tot_n = sum[huff_pkg::TOTAL_W] ? '1 : sum[huff_pkg::TOTAL_W-1:0];
    has_out = (cnt_n >= huff_pkg::CNT_W'(8)) || (q_head_i.eos && (cnt_n != '0));

    busy_d  = busy_q && !(emit && done);
    ld_d    = ld_q;
    err_d   = err_q;
    eos_d   = eos_q;
    acc_d   = acc_q;
    cnt_d   = cnt_e;
    total_d = base_total;

    if (pop) begin
      if (q_head_i.is_load) begin
        busy_d = 1'b1;
        ld_d   = 1'b1;
        err_d  = q_head_i.err;
        eos_d  = 1'b0;
        acc_d  = huff_pkg::ACC_W'(pend);
      end else begin
        busy_d  = has_out;
        ld_d    = 1'b0;
        err_d   = 1'b0;
        eos_d   = q_head_i.eos;
        acc_d   = acc_n;
        cnt_d   = cnt_n;
        total_d = (!has_out && q_head_i.eos) ? '0 : tot_n;
      end
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ld_q        <= 1'b0;
      cnt_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      ld_q        <= ld_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    eos_q <= eos_d;
    acc_q <= acc_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_idle_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q < huff_pkg::CNT_W'(8))
    else $error("packer idle with a full byte pending");

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !ld_q) |-> (cnt_q >= huff_pkg::CNT_W'(8) || (eos_q && cnt_q != '0)))
    else $error("packer busy with nothing to emit");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.valid_bits == '0) |-> out_q.last)
    else $error("status word without last");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT = 16;
  localparam int CALM_FIRST = 120;
  localparam int CALM_LAST = 220;
  localparam int RANDOM_ITEMS = 305;

  typedef struct packed {
    huff_pkg::in_word_t word;
    logic               drain;
  } stim_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  huff_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  huff_pkg::out_word_t out_word_o;

  stim_t               pending_items[$];
  huff_pkg::out_word_t expected_bytes[$];
  stim_t               next_item;
  huff_pkg::out_word_t want;
  int                  mismatch_count = 0;
  int                  words_accepted = 0;
  int                  quiet_cycles = 0;
  logic                calm = 1'b0;

  // predictor state
  logic [huff_pkg::CODE_W-1:0]  tbl_code [SYMBOL_COUNT];
  logic [huff_pkg::LEN_W-1:0]   tbl_len [SYMBOL_COUNT];
  logic [63:0]                  pend_bits = '0;
  int                           pend_count = 0;
  logic [huff_pkg::TOTAL_W-1:0] stream_bits = '0;

  // stimulus-side bookkeeping
  logic               sym_loaded [SYMBOL_COUNT];
  logic [7:0]         loaded_syms[$];

  huffman_code_bit_packer #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic predict_bytes(input huff_pkg::in_word_t w);
    huff_pkg::out_word_t r;
    logic [63:0]         acc;
    logic [63:0]         sum;
    logic [63:0]         mask;
    int                  clen;
    int                  cnt;
    int                  n;
    r = '0;
    n = 0;
    if (w.opcode == huff_pkg::OP_LOAD) begin
      r.last = 1'b1;
      r.total_bits = stream_bits;
      if (w.code_length > MAX_CODE_LEN) begin
        r.error = 1'b1;
      end else begin
        mask = (64'd1 << w.code_length) - 64'd1;
        tbl_code[w.symbol] = w.code_bits & mask[huff_pkg::CODE_W-1:0];
        tbl_len[w.symbol] = w.code_length;
      end
      expected_bytes = {expected_bytes, r};
    end else begin
      clen = int'(tbl_len[w.symbol]);
      sum = {32'd0, stream_bits} + 64'(clen);
      stream_bits = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      acc = (pend_bits << clen) | {32'd0, tbl_code[w.symbol]};
      cnt = pend_count + clen;
      while (cnt >= huff_pkg::BYTE_W) begin
        r = '0;
        r.packed_byte = 8'(acc >> (cnt - huff_pkg::BYTE_W));
        r.valid_bits = 4'd8;
        r.total_bits = stream_bits;
        expected_bytes = {expected_bytes, r};
        cnt -= huff_pkg::BYTE_W;
        n++;
      end
      acc &= (64'd1 << cnt) - 64'd1;
      if (w.end_of_stream && cnt > 0) begin
        r = '0;
        r.packed_byte = 8'(acc << (huff_pkg::BYTE_W - cnt));
        r.valid_bits = 4'(cnt);
        r.total_bits = stream_bits;
        expected_bytes = {expected_bytes, r};
        cnt = 0;
        acc = '0;
        n++;
      end
      pend_bits = acc;
      pend_count = cnt;
      if (n > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
      if (w.end_of_stream) stream_bits = '0;
    end
  endtask

  task automatic add_load(input logic [7:0] sym, input logic [31:0] code,
                          input logic [5:0] len, input logic drain);
    stim_t s;
    s.word.opcode = huff_pkg::OP_LOAD;
    s.word.symbol = sym;
    s.word.code_bits = code;
    s.word.code_length = len;
    s.word.end_of_stream = 1'($urandom_range(0, 1));
    s.drain = drain;
    pending_items = {pending_items, s};
    if (len <= MAX_CODE_LEN && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms = {loaded_syms, sym};
    end
  endtask

  task automatic add_encode(input logic [7:0] sym, input logic eos, input logic drain);
    stim_t s;
    s.word.opcode = huff_pkg::OP_ENCODE;
    s.word.symbol = sym;
    s.word.code_bits = $urandom;
    s.word.code_length = 6'($urandom_range(0, 63));
    s.word.end_of_stream = eos;
    s.drain = drain;
    pending_items = {pending_items, s};
  endtask

  function automatic logic [5:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 6'd0;
    if (r < 75) return 6'($urandom_range(1, 10));
    if (r < 94) return 6'($urandom_range(11, MAX_CODE_LEN));
    return 6'($urandom_range(MAX_CODE_LEN + 1, 63));
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      calm <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_bytes(in_word_i);
        words_accepted++;
        quiet_cycles = 0;
      end else if (expected_bytes.size() != 0 || out_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      calm <= (words_accepted >= CALM_FIRST && words_accepted < CALM_LAST);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 &&
            (!pending_items[0].drain || quiet_cycles >= SETTLE_CYCLES) &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          in_word_i <= next_item.word;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected word %h", out_word_o));
      end else begin
        want = expected_bytes.pop_front();
        if (out_word_o.packed_byte !== want.packed_byte)
          note_mismatch($sformatf("packed_byte %h, want %h",
                                  out_word_o.packed_byte, want.packed_byte));
        if (out_word_o.valid_bits !== want.valid_bits)
          note_mismatch($sformatf("valid_bits %0d, want %0d",
                                  out_word_o.valid_bits, want.valid_bits));
        if (out_word_o.last !== want.last)
          note_mismatch($sformatf("last %b, want %b", out_word_o.last, want.last));
        if (out_word_o.total_bits !== want.total_bits)
          note_mismatch($sformatf("total_bits %0d, want %0d",
                                  out_word_o.total_bits, want.total_bits));
        if (out_word_o.error !== want.error)
          note_mismatch($sformatf("error %b, want %b", out_word_o.error, want.error));
      end
    end
  end

  initial begin
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      tbl_code[i] = '0;
      tbl_len[i] = '0;
      sym_loaded[i] = 1'b0;
    end

    // directed
    add_load(8'd0, 32'h0000_0000, 6'd1, 1'b0);
    add_load(8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0);
    add_load(8'd1, 32'hFFFF_FFFF, 6'd0, 1'b0);
    add_load(8'd2, 32'hA5A5_A5A5, 6'd5, 1'b0);
    add_load(8'd3, 32'hFFFF_FFFF, 6'd33, 1'b0);
    add_load(8'd4, 32'hFFFF_FFFF, 6'd63, 1'b0);
    add_load(8'd128, 32'h1234_5678, 6'd31, 1'b0);
    add_load(8'd6, 32'h0000_007F, 6'd7, 1'b0);
    add_encode(8'd0, 1'b0, 1'b0);
    add_encode(8'd255, 1'b0, 1'b0);
    add_encode(8'd1, 1'b1, 1'b0);
    add_encode(8'd1, 1'b1, 1'b0);
    add_encode(8'd2, 1'b0, 1'b1);
    add_load(8'd5, 32'hFFFF_FF55, 6'd7, 1'b1);
    add_encode(8'd5, 1'b1, 1'b0);
    add_encode(8'd6, 1'b0, 1'b0);
    add_encode(8'd255, 1'b1, 1'b0);
    add_encode(8'd128, 1'b0, 1'b0);
    add_encode(8'd128, 1'b1, 1'b0);
    add_load(8'd255, 32'h0000_0000, 6'd32, 1'b0);
    add_encode(8'd255, 1'b1, 1'b0);

    // random streams with loads mixed in
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 99) < 18) begin
        add_load(8'($urandom_range(0, 255)), $urandom, pick_len(), k % 60 == 59);
      end else begin
        add_encode(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                   $urandom_range(0, 7) == 0, k % 60 == 59);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
